// ===== design/mpqs_pkg.sv =====
// ----------------------------------------------------------------------------
// mpqs_pkg
// Shared sizes, codes and controller/datapath command types for the
// mergeable priority queue block (leftist heaps with parent links).
// ----------------------------------------------------------------------------
`default_nettype none
package mpqs_pkg;

  localparam int NODES       = 1024;
  localparam int MEM_DEPTH   = NODES + 1;
  localparam int IDX_W       = 11;
  localparam int KEY_W       = 31;
  localparam int NPL_W       = 4;
  localparam int OP_W        = 2;
  localparam int STACK_DEPTH = 36;
  localparam int SP_W        = 6;

  typedef logic [IDX_W-1:0] idx_t;
  typedef logic [KEY_W-1:0] key_t;
  typedef logic [NPL_W-1:0] npl_t;
  typedef logic [SP_W-1:0]  sp_t;

  typedef enum logic [OP_W-1:0] {
    OP_LOAD  = 2'd0,
    OP_MERGE = 2'd1,
    OP_POP   = 2'd2,
    OP_NONE  = 2'd3
  } op_code_t;

  // node status: loaded bit, deleted bit
  typedef enum logic [1:0] {
    ST_FREE = 2'b00,
    ST_BAD  = 2'b01,
    ST_LIVE = 2'b10,
    ST_DEAD = 2'b11
  } node_stat_t;

  typedef enum logic [4:0] {
    DP_NOP,
    DP_CLEAR,
    DP_LATCH,
    DP_RD_X,
    DP_RD_Y,
    DP_LOAD_WR,
    DP_WALK_X,
    DP_WALK_RD,
    DP_WALK_NEXT,
    DP_SAVE_RX,
    DP_JOIN_MERGE,
    DP_POP_RD,
    DP_POP_CAP,
    DP_POP_WR1,
    DP_POP_WR2,
    DP_POP_WR3,
    DP_JA,
    DP_JB,
    DP_JC,
    DP_JEND,
    DP_UPOP,
    DP_UX,
    DP_UL,
    DP_UN1,
    DP_UN2,
    DP_FIN,
    DP_EMIT
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
  } dp_cmd_t;

  typedef struct packed {
    logic clr_done;
    logic op_load;
    logic op_merge;
    logic op_pop;
    logic idx_ok;
    logic stat_live;
    logic stat_loadable;
    logic par_eq;
    logic same_root;
    logic join_zero;
    logic depth_zero;
    logic out_free;
  } dp_status_t;

endpackage
`default_nettype wire

// ===== design/mpqs_if.sv =====
// ----------------------------------------------------------------------------
// mpqs_if
// Valid/ready channels: request channel and result channel.
// ----------------------------------------------------------------------------
`default_nettype none
interface mpqs_in_if import mpqs_pkg::*; ();
  logic       valid;
  logic       ready;
  logic [1:0] operation;
  idx_t       first_index;
  idx_t       second_index;
  key_t       load_value;

  modport source (output valid, operation, first_index, second_index, load_value,
                  input ready);
  modport sink   (input valid, operation, first_index, second_index, load_value,
                  output ready);
endinterface

interface mpqs_out_if import mpqs_pkg::*; ();
  logic valid;
  logic ready;
  logic found;
  key_t min_value;

  modport source (output valid, found, min_value, input ready);
  modport sink   (input valid, found, min_value, output ready);
endinterface
`default_nettype wire

// ===== design/mergeable_priority_queue_sets_core.sv =====
// ----------------------------------------------------------------------------
// mergeable_priority_queue_sets_core
// Up to 1024 elements kept in leftist min-heaps with parent links.
// Requests: load element key, merge the heaps of two elements, pop minimum.
// ----------------------------------------------------------------------------
// Usage:
//   in_chan carries requests (operation, first_index, second_index,
//   load_value); a request moves when valid and ready are both high.
//   out_chan carries one result (found, min_value) for each pop request;
//   load, merge and unknown requests give no result.
//   One request is worked at a time. A merge follows the parent links from
//   each element to its root, walks the two right spines and relinks the
//   spine nodes bottom-up; a pop adds root cleanup and presents the result.
//   After reset every node status entry is cleared, with ready held low;
//   then the block idles with ready high.
//   A pop result sits in an output register; if the receiver stalls, the
//   next request is still taken, and a later pop waits until the register
//   is free.
// ----------------------------------------------------------------------------
`default_nettype none
module mergeable_priority_queue_sets_core import mpqs_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  mpqs_in_if.sink   in_chan,
  mpqs_out_if.source out_chan
);

  dp_cmd_t    cmd;
  dp_status_t sts;

  // sequencer
  mpqs_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_chan.valid),
    .in_ready (in_chan.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // memories and working registers
  mpqs_dp u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .sts             (sts),
    .in_operation    (in_chan.operation),
    .in_first_index  (in_chan.first_index),
    .in_second_index (in_chan.second_index),
    .in_load_value   (in_chan.load_value),
    .out_valid       (out_chan.valid),
    .out_ready       (out_chan.ready),
    .out_found       (out_chan.found),
    .out_min_value   (out_chan.min_value)
  );

endmodule
`default_nettype wire

// ===== design/mpqs_dp.sv =====
// ----------------------------------------------------------------------------
// mpqs_dp
// Datapath: node memories, spine stack, walk and merge registers and the
// result register. Carries out one command from the controller per cycle.
// ----------------------------------------------------------------------------
`default_nettype none
module mpqs_dp import mpqs_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire dp_cmd_t    cmd,
  output dp_status_t      sts,
  input  wire logic [1:0] in_operation,
  input  wire idx_t       in_first_index,
  input  wire idx_t       in_second_index,
  input  wire key_t       in_load_value,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic            out_found,
  output key_t            out_min_value
);

  // node memories
  key_t       key_mem  [MEM_DEPTH];
  idx_t       par_mem  [MEM_DEPTH];
  idx_t       left_mem [MEM_DEPTH];
  idx_t       right_mem[MEM_DEPTH];
  npl_t       npl_mem  [MEM_DEPTH];
  logic [1:0] stat_mem [MEM_DEPTH];
  idx_t       stack_mem[STACK_DEPTH];

  key_t       rd_key;
  idx_t       rd_par, rd_left, rd_right;
  npl_t       rd_npl;
  logic [1:0] rd_stat;
  idx_t       stack_q;

  // request and working registers
  logic [1:0] op_r;
  idx_t x_r, y_r, i_r, rx_r, a_r, b_r, ra_r, cur_r, ux_r, ul_r, pl_r, pr_r;
  key_t key_in_r, ka_r, minv_r;
  npl_t nl_r;
  sp_t  depth_r;
  idx_t clr_r;
  logic fnd_r;
  logic out_valid_r, out_found_r;
  key_t out_min_r;

  idx_t raddr;
  logic stat_we, key_we, par_we, lr_we, npl_we;
  idx_t stat_wa, key_wa, par_wa, lr_wa, npl_wa;
  logic [1:0] stat_wd;
  idx_t par_wd, left_wd, right_wd;
  npl_t npl_wd;

  logic b_first;
  idx_t winner;
  npl_t nc;
  logic swap;
  logic x_ok, y_ok;

  // merge step compare and unwind swap decision
  assign b_first = (rd_key < ka_r) || ((rd_key == ka_r) && (b_r < a_r));
  assign winner  = b_first ? b_r : a_r;
  assign nc      = (cur_r == '0) ? '0 : rd_npl;
  assign swap    = nl_r < nc;
  assign x_ok    = (x_r != '0) && (x_r <= IDX_W'(NODES));
  assign y_ok    = (y_r != '0) && (y_r <= IDX_W'(NODES));

  // shared read address
  always_comb begin
    case (cmd.op)
      DP_RD_Y:                raddr = y_r;
      DP_WALK_RD, DP_POP_RD:  raddr = i_r;
      DP_JA:                  raddr = a_r;
      DP_JB:                  raddr = b_r;
      DP_UX:                  raddr = stack_q;
      DP_UL:                  raddr = rd_left;
      DP_UN1:                 raddr = cur_r;
      default:                raddr = x_r;
    endcase
  end

  // write port controls
  always_comb begin
    stat_we = 1'b0; stat_wa = x_r; stat_wd = ST_LIVE;
    key_we  = 1'b0; key_wa  = x_r;
    par_we  = 1'b0; par_wa  = x_r; par_wd = x_r;
    lr_we   = 1'b0; lr_wa   = x_r; left_wd = '0; right_wd = '0;
    npl_we  = 1'b0; npl_wa  = x_r; npl_wd = NPL_W'(1);
    case (cmd.op)
      DP_CLEAR: begin
        stat_we = 1'b1; stat_wa = clr_r; stat_wd = ST_FREE;
      end
      DP_LOAD_WR: begin
        stat_we = 1'b1; key_we = 1'b1; par_we = 1'b1; lr_we = 1'b1; npl_we = 1'b1;
      end
      DP_POP_WR1: begin
        stat_we = 1'b1; stat_wa = i_r; stat_wd = ST_DEAD;
        par_we = 1'b1; par_wa = i_r; par_wd = i_r;
        lr_we = 1'b1; lr_wa = i_r;
      end
      DP_POP_WR2: begin
        par_we = (pl_r != '0); par_wa = pl_r; par_wd = pl_r;
      end
      DP_POP_WR3: begin
        par_we = (pr_r != '0); par_wa = pr_r; par_wd = pr_r;
      end
      DP_UX: begin
        par_we = (cur_r != '0); par_wa = cur_r; par_wd = stack_q;
      end
      DP_FIN: begin
        par_we = (cur_r != '0); par_wa = cur_r; par_wd = cur_r;
      end
      DP_UN2: begin
        lr_we = 1'b1; lr_wa = ux_r;
        left_wd  = swap ? cur_r : ul_r;
        right_wd = swap ? ul_r : cur_r;
        npl_we = 1'b1; npl_wa = ux_r;
        npl_wd = swap ? npl_t'(nl_r + 1'b1) : npl_t'(nc + 1'b1);
      end
      default: ;
    endcase
  end

  // node memories, registered read
  always_ff @(posedge clk) begin
    if (stat_we) stat_mem[stat_wa] <= stat_wd;
    if (key_we)  key_mem[key_wa]   <= key_in_r;
    if (par_we)  par_mem[par_wa]   <= par_wd;
    if (lr_we) begin
      left_mem[lr_wa]  <= left_wd;
      right_mem[lr_wa] <= right_wd;
    end
    if (npl_we)  npl_mem[npl_wa]   <= npl_wd;
    rd_stat  <= stat_mem[raddr];
    rd_key   <= key_mem[raddr];
    rd_par   <= par_mem[raddr];
    rd_left  <= left_mem[raddr];
    rd_right <= right_mem[raddr];
    rd_npl   <= npl_mem[raddr];
  end

  // spine stack
  always_ff @(posedge clk) begin
    if (cmd.op == DP_JC) stack_mem[depth_r] <= winner;
    if (cmd.op == DP_UPOP) stack_q <= stack_mem[sp_t'(depth_r - 1'b1)];
  end

  // working registers
  always_ff @(posedge clk) begin
    case (cmd.op)
      DP_LATCH: begin
        op_r <= in_operation; x_r <= in_first_index; y_r <= in_second_index;
        key_in_r <= in_load_value; fnd_r <= 1'b0; minv_r <= '0;
      end
      DP_WALK_X:     i_r <= x_r;
      DP_WALK_NEXT:  i_r <= rd_par;
      DP_SAVE_RX: begin
        rx_r <= i_r; i_r <= y_r;
      end
      DP_JOIN_MERGE: begin
        a_r <= rx_r; b_r <= i_r;
      end
      DP_POP_CAP: begin
        minv_r <= rd_key; fnd_r <= 1'b1; pl_r <= rd_left; pr_r <= rd_right;
      end
      DP_POP_WR3: begin
        a_r <= pl_r; b_r <= pr_r;
      end
      DP_JB: begin
        ka_r <= rd_key; ra_r <= rd_right;
      end
      DP_JC: begin
        a_r <= b_first ? rd_right : ra_r;
        b_r <= b_first ? a_r : b_r;
      end
      DP_JEND:       cur_r <= (a_r != '0) ? a_r : b_r;
      DP_UX:         ux_r <= stack_q;
      DP_UL:         ul_r <= rd_left;
      DP_UN1:        nl_r <= (ul_r == '0) ? '0 : rd_npl;
      DP_UN2:        cur_r <= ux_r;
      default: ;
    endcase
  end

  // stack depth and clearing counter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      depth_r <= '0;
      clr_r   <= '0;
    end else begin
      if (cmd.op == DP_JOIN_MERGE || cmd.op == DP_POP_WR3) depth_r <= '0;
      else if (cmd.op == DP_JC) depth_r <= sp_t'(depth_r + 1'b1);
      else if (cmd.op == DP_UPOP) depth_r <= sp_t'(depth_r - 1'b1);
      if (cmd.op == DP_CLEAR) clr_r <= idx_t'(clr_r + 1'b1);
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.op == DP_EMIT) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.op == DP_EMIT) begin
      out_found_r <= fnd_r;
      out_min_r   <= minv_r;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_found     = out_found_r;
  assign out_min_value = out_min_r;

  // status to the controller
  always_comb begin
    sts.clr_done      = (clr_r == IDX_W'(NODES));
    sts.op_load       = (op_r == OP_LOAD);
    sts.op_merge      = (op_r == OP_MERGE);
    sts.op_pop        = (op_r == OP_POP);
    sts.idx_ok        = x_ok && ((op_r != OP_MERGE) || y_ok);
    sts.stat_live     = (rd_stat == ST_LIVE);
    sts.stat_loadable = (rd_stat == ST_FREE) || (rd_stat == ST_DEAD);
    sts.par_eq        = (rd_par == i_r);
    sts.same_root     = (rx_r == i_r);
    sts.join_zero     = (a_r == '0) || (b_r == '0);
    sts.depth_zero    = (depth_r == '0);
    sts.out_free      = !out_valid_r || out_ready;
  end

`ifndef SYNTH
  a_depth_bound: assert property (@(posedge clk) disable iff (!rst_n)
    depth_r <= SP_W'(STACK_DEPTH))
    else $error("spine stack depth out of range");
  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.op == DP_UPOP |-> depth_r != '0)
    else $error("unwind pop on empty spine stack");
  a_emit_valid: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.op == DP_EMIT |=> out_valid_r)
    else $error("emitted result not presented");
  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_found_r |-> out_min_r == '0)
    else $error("miss result carries nonzero key");
`endif

endmodule
`default_nettype wire

// ===== design/mpqs_ctrl.sv =====
// ----------------------------------------------------------------------------
// mpqs_ctrl
// Controller: sequences clearing, load, merge (root walks, spine walk,
// bottom-up relink) and pop, issuing one datapath command per cycle.
// ----------------------------------------------------------------------------
`default_nettype none
module mpqs_ctrl import mpqs_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire dp_status_t sts,
  output dp_cmd_t         cmd
);

  typedef enum logic [26:0] {
    S_CLEAR  = 27'h0000001,
    S_IDLE   = 27'h0000002,
    S_DECODE = 27'h0000004,
    S_LD_CHK = 27'h0000008,
    S_M_CHK1 = 27'h0000010,
    S_M_CHK2 = 27'h0000020,
    S_WX_RD  = 27'h0000040,
    S_WX_CHK = 27'h0000080,
    S_WY_RD  = 27'h0000100,
    S_WY_CHK = 27'h0000200,
    S_P_CHK  = 27'h0000400,
    S_WP_RD  = 27'h0000800,
    S_WP_CHK = 27'h0001000,
    S_P_CAP  = 27'h0002000,
    S_P_WR1  = 27'h0004000,
    S_P_WR2  = 27'h0008000,
    S_P_WR3  = 27'h0010000,
    S_J_TEST = 27'h0020000,
    S_JB     = 27'h0040000,
    S_JC     = 27'h0080000,
    S_UPOP   = 27'h0100000,
    S_UX     = 27'h0200000,
    S_UL     = 27'h0400000,
    S_UN1    = 27'h0800000,
    S_UN2    = 27'h1000000,
    S_FIN    = 27'h2000000,
    S_EMIT   = 27'h4000000
  } state_t;

  state_t state_r, state_nxt;

  assign in_ready = (state_r == S_IDLE);

  // next state and command
  always_comb begin
    state_nxt = state_r;
    cmd.op    = DP_NOP;
    unique case (state_r)
      S_CLEAR: begin
        cmd.op = DP_CLEAR;
        if (sts.clr_done) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.op = DP_LATCH;
          state_nxt = S_DECODE;
        end
      end
      S_DECODE: begin
        if (!sts.idx_ok) begin
          state_nxt = sts.op_pop ? S_EMIT : S_IDLE;
        end else if (sts.op_load) begin
          cmd.op = DP_RD_X; state_nxt = S_LD_CHK;
        end else if (sts.op_merge) begin
          cmd.op = DP_RD_X; state_nxt = S_M_CHK1;
        end else if (sts.op_pop) begin
          cmd.op = DP_RD_X; state_nxt = S_P_CHK;
        end else begin
          state_nxt = S_IDLE;
        end
      end
      S_LD_CHK: begin
        if (sts.stat_loadable) cmd.op = DP_LOAD_WR;
        state_nxt = S_IDLE;
      end
      S_M_CHK1: begin
        if (sts.stat_live) begin
          cmd.op = DP_RD_Y; state_nxt = S_M_CHK2;
        end else begin
          state_nxt = S_IDLE;
        end
      end
      S_M_CHK2: begin
        if (sts.stat_live) begin
          cmd.op = DP_WALK_X; state_nxt = S_WX_RD;
        end else begin
          state_nxt = S_IDLE;
        end
      end
      S_WX_RD: begin
        cmd.op = DP_WALK_RD; state_nxt = S_WX_CHK;
      end
      S_WX_CHK: begin
        if (sts.par_eq) begin
          cmd.op = DP_SAVE_RX; state_nxt = S_WY_RD;
        end else begin
          cmd.op = DP_WALK_NEXT; state_nxt = S_WX_RD;
        end
      end
      S_WY_RD: begin
        cmd.op = DP_WALK_RD; state_nxt = S_WY_CHK;
      end
      S_WY_CHK: begin
        if (!sts.par_eq) begin
          cmd.op = DP_WALK_NEXT; state_nxt = S_WY_RD;
        end else if (sts.same_root) begin
          state_nxt = S_IDLE;
        end else begin
          cmd.op = DP_JOIN_MERGE; state_nxt = S_J_TEST;
        end
      end
      S_P_CHK: begin
        if (sts.stat_live) begin
          cmd.op = DP_WALK_X; state_nxt = S_WP_RD;
        end else begin
          state_nxt = S_EMIT;
        end
      end
      S_WP_RD: begin
        cmd.op = DP_WALK_RD; state_nxt = S_WP_CHK;
      end
      S_WP_CHK: begin
        if (sts.par_eq) begin
          cmd.op = DP_POP_RD; state_nxt = S_P_CAP;
        end else begin
          cmd.op = DP_WALK_NEXT; state_nxt = S_WP_RD;
        end
      end
      S_P_CAP: begin
        cmd.op = DP_POP_CAP; state_nxt = S_P_WR1;
      end
      S_P_WR1: begin
        cmd.op = DP_POP_WR1; state_nxt = S_P_WR2;
      end
      S_P_WR2: begin
        cmd.op = DP_POP_WR2; state_nxt = S_P_WR3;
      end
      S_P_WR3: begin
        cmd.op = DP_POP_WR3; state_nxt = S_J_TEST;
      end
      // spine walk: each node passes through S_J_TEST, S_JB and S_JC
      S_J_TEST: begin
        if (sts.join_zero) begin
          cmd.op = DP_JEND; state_nxt = S_UPOP;
        end else begin
          cmd.op = DP_JA; state_nxt = S_JB;
        end
      end
      S_JB: begin
        cmd.op = DP_JB; state_nxt = S_JC;
      end
      S_JC: begin
        cmd.op = DP_JC; state_nxt = S_J_TEST;
      end
      // bottom-up relink: each stacked node passes through S_UPOP, S_UX, S_UL, S_UN1 and S_UN2
      S_UPOP: begin
        if (sts.depth_zero) begin
          state_nxt = S_FIN;
        end else begin
          cmd.op = DP_UPOP; state_nxt = S_UX;
        end
      end
      S_UX: begin
        cmd.op = DP_UX; state_nxt = S_UL;
      end
      S_UL: begin
        cmd.op = DP_UL; state_nxt = S_UN1;
      end
      S_UN1: begin
        cmd.op = DP_UN1; state_nxt = S_UN2;
      end
      S_UN2: begin
        cmd.op = DP_UN2; state_nxt = S_UPOP;
      end
      S_FIN: begin
        cmd.op = DP_FIN;
        state_nxt = sts.op_pop ? S_EMIT : S_IDLE;
      end
      S_EMIT: begin
        if (sts.out_free) begin
          cmd.op = DP_EMIT; state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

`ifndef SYNTH
  a_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot(state_r))
    else $error("controller state not one-hot");
  a_accept_latch: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> state_r == S_DECODE)
    else $error("accepted request not decoded");
  a_emit_only_pop: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_EMIT |-> sts.op_pop)
    else $error("result emitted for non-pop request");
`endif

endmodule
`default_nettype wire
